FILE: sv/sca_pkg.sv
// Shared types and constants for the selector-channel DMA addresser.
package sca_pkg;

  localparam int unsigned AddrBits  = 20;
  localparam int unsigned DataBits  = 8;
  localparam int unsigned WordBits  = 32;
  localparam int unsigned CountBits = 8;

  localparam logic [CountBits-1:0] ArmedCount = CountBits'(4);
  localparam logic [DataBits-1:0]  PortReadValue = '1;

  // Mode bits in the low byte of the shift word.
  localparam int unsigned ModeWriteBit = 7;
  localparam int unsigned ModeIoBit    = 6;
  localparam int unsigned ModeUpBit    = 5;

  typedef enum logic [1:0] {
    OpPortWrite = 2'd0,
    OpPortRead  = 2'd1,
    OpDmaByte   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusNotArmed = 2'd1,
    StatusIoMode   = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]          op;
    logic [DataBits-1:0] data;
    logic                last;
  } in_item_t;

  typedef struct packed {
    logic [DataBits-1:0] read_data;
    logic                mem_valid;
    logic                mem_write;
    logic [AddrBits-1:0] mem_addr;
    logic [DataBits-1:0] mem_wdata;
    logic [1:0]          status;
  } result_t;

endpackage

FILE: sv/sca_in_stage.sv
// Input register stage: holds one accepted item until the engine takes it.
module sca_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  sca_pkg::in_item_t  item_i,
  input  logic               take_i,
  output logic               valid_o,
  output sca_pkg::in_item_t  item_o
);

  logic              valid_q, valid_d;
  sca_pkg::in_item_t item_q;
  logic              load;

  assign load = in_valid_i && !in_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: sv/sca_engine.sv
// Channel state and the single-pass logic that turns one item into its result.
module sca_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  sca_pkg::in_item_t  item_i,
  output sca_pkg::result_t   result_o
);

  logic [sca_pkg::WordBits-1:0]  shift_q, shift_d;
  logic [sca_pkg::AddrBits-1:0]  base_q, base_d;
  logic [sca_pkg::CountBits-1:0] count_q, count_d;
  logic [sca_pkg::AddrBits-1:0]  offset_q, offset_d;
  logic [sca_pkg::DataBits-1:0]  mode;
  logic [sca_pkg::AddrBits-1:0]  len;
  logic                          armed;

  assign mode  = shift_q[sca_pkg::DataBits-1:0];
  assign armed = (count_q == sca_pkg::ArmedCount);
  assign len   = offset_q + sca_pkg::AddrBits'(1);

  always_comb begin
    shift_d  = shift_q;
    base_d   = base_q;
    count_d  = count_q;
    offset_d = offset_q;
    result_o = '0;
    unique case (sca_pkg::op_e'(item_i.op))
      sca_pkg::OpPortWrite: begin
        shift_d  = {shift_q[sca_pkg::WordBits-sca_pkg::DataBits-1:0], item_i.data};
        // The base follows the freshly shifted word, bits 27..8.
        base_d   = shift_d[sca_pkg::AddrBits+7:8];
        count_d  = count_q + sca_pkg::CountBits'(1);
        offset_d = '0;
      end
      sca_pkg::OpPortRead: begin
        count_d            = '0;
        offset_d           = '0;
        result_o.read_data = sca_pkg::PortReadValue;
      end
      sca_pkg::OpDmaByte: begin
        if (!armed || mode[sca_pkg::ModeIoBit]) begin
          result_o.status = !armed ? sca_pkg::StatusNotArmed : sca_pkg::StatusIoMode;
          if (item_i.last) begin
            offset_d = '0;
          end
        end else begin
          result_o.mem_valid = 1'b1;
          result_o.mem_addr  = base_q + offset_q;
          if (mode[sca_pkg::ModeWriteBit]) begin
            result_o.mem_write = 1'b1;
            result_o.mem_wdata = item_i.data;
          end
          if (item_i.last) begin
            base_d   = mode[sca_pkg::ModeUpBit] ? base_q + len : base_q - len;
            offset_d = '0;
          end else begin
            offset_d = len;
          end
        end
      end
      default: begin
        // The unused op code leaves the state alone and gives an all-zero result.
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= '0;
      base_q   <= '0;
      count_q  <= '0;
      offset_q <= '0;
    end else if (fire_i) begin
      shift_q  <= shift_d;
      base_q   <= base_d;
      count_q  <= count_d;
      offset_q <= offset_d;
    end
  end

endmodule

FILE: sv/selector_channel_dma_addresser.sv
// Top level of the selector-channel DMA addresser with its result register.
//
// Input channel: in_valid_i / in_stall_o carry op_i, data_i and last_i. Op
// port write shifts a byte into the control word, port read returns 0xFF and
// disarms the channel, DMA byte issues one memory access when the channel is
// armed in memory mode.
// Output channel: out_valid_o / out_stall_i carry one result per item: the
// port read data, the memory access (valid, write, address, write data) and
// a status code.
// An accepted item sits in the input register while the engine computes its
// result and the channel state update in one pass; the result is then
// registered in the result register.
// Throughput is one item per cycle while the receiver does not stall; the
// engine updates the channel state in one pass.
// While the receiver stalls, the result register holds its item and the
// input register can still take one more item before in_stall_o rises.
// Reset clears the control word, base address, write counter and byte
// offset, and empties both registers.
module selector_channel_dma_addresser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  data_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic        mem_valid_o,
  output logic        mem_write_o,
  output logic [19:0] mem_addr_o,
  output logic [7:0]  mem_wdata_o,
  output logic [1:0]  status_o
);

  sca_pkg::in_item_t in_item, stage_item;
  sca_pkg::result_t  result, result_q;
  logic              stage_valid;
  logic              out_valid_q;
  logic              advance;

  assign in_item.op   = op_i;
  assign in_item.data = data_i;
  assign in_item.last = last_i;

  assign advance    = stage_valid && (!out_valid_q || !out_stall_i);
  assign in_stall_o = stage_valid && !advance;

  sca_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_i (in_stall_o),
    .item_i     (in_item),
    .take_i     (advance),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  sca_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (stage_item),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = result_q.read_data;
  assign mem_valid_o = result_q.mem_valid;
  assign mem_write_o = result_q.mem_write;
  assign mem_addr_o  = result_q.mem_addr;
  assign mem_wdata_o = result_q.mem_wdata;
  assign status_o    = result_q.status;

endmodule

FILE: sv/sca_checker.sv
// Port-level checker for the selector-channel DMA addresser, bound to the top level.
module sca_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_stall_o,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [7:0]  read_data_o,
  input  logic        mem_valid_o,
  input  logic        mem_write_o,
  input  logic [19:0] mem_addr_o,
  input  logic [7:0]  mem_wdata_o,
  input  logic [1:0]  status_o
);

  // A stalled result stays and holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mem_addr_o) &&
      $stable(status_o) && $stable(mem_wdata_o) && $stable(read_data_o))
    else $error("stalled result changed");

  // A rejected DMA byte never issues a memory access.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != sca_pkg::StatusOk |-> !mem_valid_o)
    else $error("memory access issued with a non-zero status");

  // Without an access, every access field is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !mem_valid_o |->
      !mem_write_o && mem_addr_o == 20'd0 && mem_wdata_o == 8'd0)
    else $error("access fields set without an access");

  // A port read result carries 0xFF and nothing else.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_data_o != 8'd0 |->
      read_data_o == sca_pkg::PortReadValue && !mem_valid_o &&
      status_o == sca_pkg::StatusOk)
    else $error("malformed port read result");

  // The input only stalls while a result waits on a stalled receiver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

endmodule

bind selector_channel_dma_addresser sca_checker u_sca_checker (.*);

FILE: dv/selector_channel_dma_addresser_test.sv
// Self-checking testbench for the selector-channel DMA addresser.
module selector_channel_dma_addresser_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OpUnused   = 2'd3;
  localparam int         TotalItems = 950;
  localparam int         QuietFrom  = 800;
  localparam int         WrapAt     = 400;
  localparam int         HoldAt     = 300;
  localparam int         HoldCycles = 60;

  localparam sca_pkg::result_t ExpNone     = '0;
  localparam sca_pkg::result_t ExpNotArmed = '{status: sca_pkg::StatusNotArmed, default: '0};
  localparam sca_pkg::result_t ExpIoMode   = '{status: sca_pkg::StatusIoMode, default: '0};
  localparam sca_pkg::result_t ExpPortRead = '{read_data: sca_pkg::PortReadValue,
                                               default: '0};

  typedef struct packed {
    logic [1:0]       op;
    logic [7:0]       data;
    logic             last;
    logic             typed;
    sca_pkg::result_t want;
  } plan_row_t;

  localparam int PlanRows = 26;
  localparam plan_row_t DirectedPlan [PlanRows] = '{
    '{sca_pkg::OpDmaByte,   8'hFF, 1'b1, 1'b1, ExpNotArmed},  // straight after reset
    '{sca_pkg::OpPortRead,  8'h00, 1'b0, 1'b1, ExpPortRead},
    '{OpUnused,             8'hFF, 1'b1, 1'b1, ExpNone},
    '{sca_pkg::OpPortWrite, 8'h12, 1'b0, 1'b1, ExpNone},
    '{sca_pkg::OpPortWrite, 8'h34, 1'b1, 1'b1, ExpNone},
    '{sca_pkg::OpPortWrite, 8'h56, 1'b0, 1'b1, ExpNone},
    '{sca_pkg::OpPortWrite, 8'hA0, 1'b0, 1'b1, ExpNone},      // memory write, counting up
    '{sca_pkg::OpDmaByte,   8'hFF, 1'b0, 1'b0, ExpNone},
    '{sca_pkg::OpDmaByte,   8'h00, 1'b1, 1'b0, ExpNone},
    '{sca_pkg::OpDmaByte,   8'h5A, 1'b1, 1'b0, ExpNone},
    '{sca_pkg::OpPortWrite, 8'h00, 1'b0, 1'b1, ExpNone},      // fifth write disarms
    '{sca_pkg::OpDmaByte,   8'h77, 1'b0, 1'b1, ExpNotArmed},
    '{sca_pkg::OpPortRead,  8'hFF, 1'b1, 1'b1, ExpPortRead},
    '{sca_pkg::OpPortWrite, 8'hFF, 1'b0, 1'b1, ExpNone},
    '{sca_pkg::OpPortWrite, 8'hFF, 1'b0, 1'b1, ExpNone},
    '{sca_pkg::OpPortWrite, 8'hFF, 1'b0, 1'b1, ExpNone},
    '{sca_pkg::OpPortWrite, 8'h5F, 1'b0, 1'b1, ExpNone},      // I/O mode
    '{sca_pkg::OpDmaByte,   8'h01, 1'b1, 1'b1, ExpIoMode},
    '{sca_pkg::OpPortRead,  8'h00, 1'b0, 1'b1, ExpPortRead},
    '{sca_pkg::OpPortWrite, 8'h00, 1'b0, 1'b1, ExpNone},
    '{sca_pkg::OpPortWrite, 8'h00, 1'b0, 1'b1, ExpNone},
    '{sca_pkg::OpPortWrite, 8'h00, 1'b0, 1'b1, ExpNone},
    '{sca_pkg::OpPortWrite, 8'h1F, 1'b0, 1'b1, ExpNone},      // read, down, priority bits set
    '{sca_pkg::OpDmaByte,   8'hC3, 1'b0, 1'b0, ExpNone},
    '{sca_pkg::OpDmaByte,   8'h3C, 1'b1, 1'b0, ExpNone},      // base wraps below zero
    '{sca_pkg::OpDmaByte,   8'h81, 1'b1, 1'b0, ExpNone}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i = sca_pkg::OpPortWrite;
  logic [7:0]  data_i = '0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  read_data_o;
  logic        mem_valid_o;
  logic        mem_write_o;
  logic [19:0] mem_addr_o;
  logic [7:0]  mem_wdata_o;
  logic [1:0]  status_o;

  // Predicted channel state.
  logic [31:0] ctl_word = '0;
  logic [19:0] dma_base = '0;
  logic [7:0]  port_writes = '0;
  logic [19:0] xfer_offset = '0;

  sca_pkg::result_t pending_results [$];
  int               issued_items = 0;
  int               mismatches = 0;
  bit               idle_on = 1'b1;
  bit               recv_holding = 1'b0;

  selector_channel_dma_addresser i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .data_i      (data_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_data_o (read_data_o),
    .mem_valid_o (mem_valid_o),
    .mem_write_o (mem_write_o),
    .mem_addr_o  (mem_addr_o),
    .mem_wdata_o (mem_wdata_o),
    .status_o    (status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic sca_pkg::result_t predict_access(logic [1:0] op, logic [7:0] data,
                                                      logic last);
    sca_pkg::result_t r;
    logic [7:0]       mode;
    logic [19:0]      len;
    r = '0;
    mode = ctl_word[7:0];
    case (op)
      sca_pkg::OpPortWrite: begin
        ctl_word = {ctl_word[23:0], data};
        dma_base = ctl_word[27:8];
        port_writes = port_writes + 8'd1;
        xfer_offset = '0;
      end
      sca_pkg::OpPortRead: begin
        port_writes = '0;
        xfer_offset = '0;
        r.read_data = sca_pkg::PortReadValue;
      end
      sca_pkg::OpDmaByte: begin
        // The armed check takes precedence over the I/O-mode check.
        if (port_writes != sca_pkg::ArmedCount) begin
          r.status = sca_pkg::StatusNotArmed;
        end else if (mode[sca_pkg::ModeIoBit]) begin
          r.status = sca_pkg::StatusIoMode;
        end
        if (r.status != sca_pkg::StatusOk) begin
          if (last) xfer_offset = '0;
        end else begin
          r.mem_valid = 1'b1;
          r.mem_addr = dma_base + xfer_offset;
          if (mode[sca_pkg::ModeWriteBit]) begin
            r.mem_write = 1'b1;
            r.mem_wdata = data;
          end
          if (last) begin
            len = xfer_offset + 20'd1;
            dma_base = mode[sca_pkg::ModeUpBit] ? dma_base + len : dma_base - len;
            xfer_offset = '0;
          end else begin
            xfer_offset = xfer_offset + 20'd1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [7:0] data, input logic last,
                           input bit typed = 1'b0, input sca_pkg::result_t want = '0);
    int unsigned      gap;
    sca_pkg::result_t guess;
    if (idle_on && !recv_holding && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    data_i <= data;
    last_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    guess = predict_access(op, data, last);
    pending_results.push_back(typed ? want : guess);
    if (op != OpUnused) issued_items++;
  endtask

  // Reload the shift word with a random base and the given mode, arming the channel.
  task automatic arm_channel(input logic [7:0] mode);
    int unsigned fill;
    fill = $urandom_range(0, 5);
    send_item(sca_pkg::OpPortRead, 8'($urandom), 1'($urandom));
    repeat (3) begin
      send_item(sca_pkg::OpPortWrite, fill == 0 ? 8'h00 : fill == 1 ? 8'hFF : 8'($urandom),
                1'($urandom));
    end
    send_item(sca_pkg::OpPortWrite, mode, 1'($urandom));
  endtask

  task automatic run_transfers(input int unsigned count);
    int unsigned len;
    bit          broken;
    broken = 1'b0;
    repeat (count) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int unsigned i = 0; i < len && !broken; i++) begin
        if ($urandom_range(0, 40) == 0) begin
          // A port access in the middle of a transfer restarts the offset.
          send_item($urandom_range(0, 1) ? sca_pkg::OpPortRead : sca_pkg::OpPortWrite,
                    8'($urandom), 1'($urandom));
          broken = 1'b1;
        end else begin
          send_item(sca_pkg::OpDmaByte, 8'($urandom), i == len - 1);
        end
      end
    end
  endtask

  function automatic logic [7:0] random_mode();
    logic [7:0] mode;
    mode = 8'($urandom);
    if ($urandom_range(0, 7) != 0) mode[sca_pkg::ModeIoBit] = 1'b0;
    return mode;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    sca_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: result with nothing expected, expected none, actual status %0h",
                 $time, status_o);
      end else begin
        want = pending_results.pop_front();
        compare_field("read_data", 32'(want.read_data), 32'(read_data_o));
        compare_field("mem_valid", 32'(want.mem_valid), 32'(mem_valid_o));
        compare_field("mem_write", 32'(want.mem_write), 32'(mem_write_o));
        compare_field("mem_addr", 32'(want.mem_addr), 32'(mem_addr_o));
        compare_field("mem_wdata", 32'(want.mem_wdata), 32'(mem_wdata_o));
        compare_field("status", 32'(want.status), 32'(status_o));
      end
    end
  end

  // Receiver: random stall bursts, and one long hold-off so that the block fills up.
  initial begin : result_stall
    int unsigned burst;
    bit          held;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && issued_items >= HoldAt) begin
        held = 1'b1;
        recv_holding = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
        recv_holding = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 17);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int unsigned pick;
    bit          wrapped;
    wrapped = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedPlan[k]) begin
      send_item(DirectedPlan[k].op, DirectedPlan[k].data, DirectedPlan[k].last,
                DirectedPlan[k].typed, DirectedPlan[k].want);
    end

    while (issued_items < TotalItems) begin
      idle_on = (issued_items < QuietFrom) && ($urandom_range(0, 4) != 0);
      pick = $urandom_range(0, 99);
      if (!wrapped && issued_items >= WrapAt) begin
        // The write counter wraps after 256 writes and arms the channel again.
        wrapped = 1'b1;
        send_item(sca_pkg::OpPortRead, 8'($urandom), 1'b0);
        repeat (259) send_item(sca_pkg::OpPortWrite, 8'($urandom), 1'($urandom));
        send_item(sca_pkg::OpPortWrite, random_mode(), 1'b0);
        run_transfers(1);
      end else if (pick < 65) begin
        arm_channel(random_mode());
        run_transfers($urandom_range(1, 3));
      end else if (pick < 80) begin
        // Wrong number of port writes before the transfer.
        send_item(sca_pkg::OpPortRead, 8'($urandom), 1'($urandom));
        repeat ($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(5, 6)) begin
          send_item(sca_pkg::OpPortWrite, 8'($urandom), 1'($urandom));
        end
        run_transfers(1);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_item(2'($urandom), 8'($urandom), 1'($urandom));
        end
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
